// ----- rtl/core/kcl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kcl_pkg;

    localparam int CODE_LENGTH_DEF = 4;

    localparam int REQ_TYPE_W  = 2;
    localparam int DIGIT_W     = 3;
    localparam int SAMPLE_W    = 12;
    localparam int TRIES_W     = 2;
    localparam int CAP_W       = 9;
    localparam int BACKOFF_W   = 10;
    localparam int POSITION_W  = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [SAMPLE_W-1:0]  THRESHOLD_RESET   = 12'd1020;
    localparam logic [TRIES_W-1:0]   FREE_TRIES_RESET  = 2'd3;
    localparam logic [CAP_W-1:0]     BACKOFF_CAP_RESET = 9'd256;
    localparam logic [TRIES_W-1:0]   TRIES_RESET       = 2'd1;
    localparam logic [BACKOFF_W-1:0] BACKOFF_RESET     = 10'd1;

    localparam logic [DIGIT_W-1:0] KEY_MIN = 3'd1;
    localparam logic [DIGIT_W-1:0] KEY_MAX = 3'd5;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_ENTER   = 2'd1,
        MODE_VERDICT = 2'd2,
        MODE_SETCODE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REQ_KEY     = 2'd0,
        REQ_REENTER = 2'd1,
        REQ_RESET   = 2'd2,
        REQ_SAMPLE  = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        VERDICT_NONE  = 2'd0,
        VERDICT_OK    = 2'd1,
        VERDICT_WRONG = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        MOTOR_NONE    = 2'd0,
        MOTOR_RELEASE = 2'd1,
        MOTOR_ENGAGE  = 2'd2
    } motor_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD   = 2'd0,
        CFG_FREE_TRIES  = 2'd1,
        CFG_BACKOFF_CAP = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] threshold;
        logic [TRIES_W-1:0]  free_tries;
        logic [CAP_W-1:0]    backoff_cap;
    } cfg_t;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [DIGIT_W-1:0]    key_value;
        logic [SAMPLE_W-1:0]   sensor_sample;
    } req_item_t;

    typedef struct packed {
        logic [1:0]            mode_now;
        logic [POSITION_W-1:0] shown_position;
        logic [DIGIT_W-1:0]    shown_symbol;
        logic [1:0]            verdict;
        logic [BACKOFF_W-1:0]  alarm_flashes;
        logic [1:0]            motor_cmd;
        logic                  bolt_now;
        logic                  code_done;
        logic                  just_activated;
    } res_item_t;

    // default code is 1,2,3,4 repeated over the code length
    function automatic logic [DIGIT_W-1:0] reset_digit(input int pos);
        return DIGIT_W'((pos % 4) + 1);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/kcl_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface kcl_req_if;
    logic                                valid;
    logic                                ready;
    logic [kcl_pkg::REQ_TYPE_W-1:0]      req_type;
    logic [kcl_pkg::DIGIT_W-1:0]         key_value;
    logic [kcl_pkg::SAMPLE_W-1:0]        sensor_sample;

    modport source (
        output valid, req_type, key_value, sensor_sample,
        input  ready
    );

    modport sink (
        input  valid, req_type, key_value, sensor_sample,
        output ready
    );
endinterface

interface kcl_res_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          mode_now;
    logic [kcl_pkg::POSITION_W-1:0]      shown_position;
    logic [kcl_pkg::DIGIT_W-1:0]         shown_symbol;
    logic [1:0]                          verdict;
    logic [kcl_pkg::BACKOFF_W-1:0]       alarm_flashes;
    logic [1:0]                          motor_cmd;
    logic                                bolt_now;
    logic                                code_done;
    logic                                just_activated;

    modport source (
        output valid, mode_now, shown_position, shown_symbol, verdict, alarm_flashes,
               motor_cmd, bolt_now, code_done, just_activated,
        input  ready
    );

    modport sink (
        input  valid, mode_now, shown_position, shown_symbol, verdict, alarm_flashes,
               motor_cmd, bolt_now, code_done, just_activated,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/kcl_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kcl_engine #(
    parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         step,
    input  kcl_pkg::req_item_t          item,
    input  kcl_pkg::cfg_t               cfg,
    output kcl_pkg::res_item_t          res
);

    localparam int CNT_W = $clog2(CODE_LENGTH + 1);
    localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam int POS_W = (CNT_W > kcl_pkg::POSITION_W) ? CNT_W : kcl_pkg::POSITION_W;

    kcl_pkg::mode_t                    mode_reg, mode_next;
    logic [kcl_pkg::DIGIT_W-1:0]       code_reg  [CODE_LENGTH];
    logic [kcl_pkg::DIGIT_W-1:0]       code_next [CODE_LENGTH];
    logic [CNT_W-1:0]                  digit_count_reg, digit_count_next;
    logic [CODE_LENGTH-1:0]            match_flags_reg, match_flags_next;
    logic                              last_ok_reg, last_ok_next;
    logic [kcl_pkg::TRIES_W-1:0]       tries_reg, tries_next;
    logic [kcl_pkg::BACKOFF_W-1:0]     backoff_reg, backoff_next;
    logic                              bolt_reg, bolt_next;

    logic                              key_ok;
    logic                              key_step;
    logic                              last_key;
    logic                              sample_hit;
    logic                              hit;
    logic                              all_ok;
    logic                              code_we;
    logic [IDX_W-1:0]                  idx;
    logic [CNT_W-1:0]                  count_inc;
    logic [POS_W-1:0]                  pos_wide;
    logic [CODE_LENGTH-1:0]            flags_set;

    // ---- decode --------------------------------------------------------
    always_comb
    begin
        key_ok     = item.key_value inside {[kcl_pkg::KEY_MIN:kcl_pkg::KEY_MAX]};
        key_step   = (item.req_type == kcl_pkg::REQ_KEY) && key_ok
                     && (digit_count_reg < CNT_W'(CODE_LENGTH));
        idx        = digit_count_reg[IDX_W-1:0];
        count_inc  = digit_count_reg + CNT_W'(1);
        last_key   = (count_inc == CNT_W'(CODE_LENGTH));
        pos_wide   = POS_W'(digit_count_reg) + POS_W'(1);
        sample_hit = (item.req_type == kcl_pkg::REQ_SAMPLE)
                     && (item.sensor_sample >= cfg.threshold);
        hit        = (code_reg[idx] == item.key_value);
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            flags_set[i] = match_flags_reg[i] | (hit && (idx == IDX_W'(i)));
        end
        all_ok     = &flags_set;
    end

    // ---- next mode -----------------------------------------------------
    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            kcl_pkg::MODE_IDLE:
            begin
                if (sample_hit)
                    mode_next = kcl_pkg::MODE_ENTER;
            end
            kcl_pkg::MODE_ENTER:
            begin
                if (key_step && last_key)
                    mode_next = kcl_pkg::MODE_VERDICT;
                else if ((item.req_type == kcl_pkg::REQ_RESET) && bolt_reg)
                    mode_next = kcl_pkg::MODE_IDLE;
            end
            kcl_pkg::MODE_VERDICT:
            begin
                if (item.req_type == kcl_pkg::REQ_REENTER)
                    mode_next = last_ok_reg ? kcl_pkg::MODE_IDLE : kcl_pkg::MODE_ENTER;
                else if (item.req_type == kcl_pkg::REQ_RESET)
                    mode_next = last_ok_reg ? kcl_pkg::MODE_SETCODE : kcl_pkg::MODE_ENTER;
            end
            kcl_pkg::MODE_SETCODE:
            begin
                if (key_step && last_key)
                    mode_next = kcl_pkg::MODE_IDLE;
            end
            default:
            begin
                mode_next = kcl_pkg::MODE_IDLE;
            end
        endcase
    end

    // ---- datapath and result -------------------------------------------
    always_comb
    begin
        digit_count_next = digit_count_reg;
        match_flags_next = match_flags_reg;
        last_ok_next     = last_ok_reg;
        tries_next       = tries_reg;
        backoff_next     = backoff_reg;
        bolt_next        = bolt_reg;
        code_we          = 1'b0;

        res                = '0;

        case (mode_reg)
            kcl_pkg::MODE_IDLE:
            begin
                res.just_activated = sample_hit;
            end
            kcl_pkg::MODE_ENTER:
            begin
                if (key_step)
                begin
                    match_flags_next   = flags_set;
                    res.shown_position = pos_wide[kcl_pkg::POSITION_W-1:0];
                    res.shown_symbol   = item.key_value;
                    digit_count_next   = count_inc;
                    if (last_key)
                    begin
                        last_ok_next = all_ok;
                        if (all_ok)
                        begin
                            res.verdict  = kcl_pkg::VERDICT_OK;
                            tries_next   = kcl_pkg::TRIES_RESET;
                            backoff_next = kcl_pkg::BACKOFF_RESET;
                        end
                        else
                        begin
                            res.verdict       = kcl_pkg::VERDICT_WRONG;
                            res.alarm_flashes = backoff_reg;
                            if (tries_reg < cfg.free_tries)
                                tries_next = tries_reg + kcl_pkg::TRIES_W'(1);
                            else if (backoff_reg <= kcl_pkg::BACKOFF_W'(cfg.backoff_cap))
                                backoff_next = {backoff_reg[kcl_pkg::BACKOFF_W-2:0], 1'b0};
                        end
                    end
                end
                else if (item.req_type == kcl_pkg::REQ_REENTER)
                begin
                    digit_count_next = '0;
                    match_flags_next = '0;
                end
                else if (item.req_type == kcl_pkg::REQ_RESET)
                begin
                    if (bolt_reg)
                    begin
                        res.motor_cmd = kcl_pkg::MOTOR_RELEASE;
                        bolt_next     = 1'b0;
                    end
                    digit_count_next = '0;
                    match_flags_next = '0;
                end
            end
            kcl_pkg::MODE_VERDICT:
            begin
                if (item.req_type == kcl_pkg::REQ_REENTER)
                begin
                    if (last_ok_reg && !bolt_reg)
                    begin
                        res.motor_cmd = kcl_pkg::MOTOR_ENGAGE;
                        bolt_next     = 1'b1;
                    end
                    digit_count_next = '0;
                    match_flags_next = '0;
                end
                else if (item.req_type == kcl_pkg::REQ_RESET)
                begin
                    // a code change keeps the match flags; the change itself clears them
                    digit_count_next = '0;
                    if (!last_ok_reg)
                        match_flags_next = '0;
                end
            end
            kcl_pkg::MODE_SETCODE:
            begin
                if (key_step)
                begin
                    code_we            = 1'b1;
                    res.shown_position = pos_wide[kcl_pkg::POSITION_W-1:0];
                    res.shown_symbol   = item.key_value;
                    digit_count_next   = count_inc;
                    if (last_key)
                    begin
                        res.code_done    = 1'b1;
                        digit_count_next = '0;
                        match_flags_next = '0;
                    end
                end
                else if ((item.req_type == kcl_pkg::REQ_REENTER)
                         || ((item.req_type == kcl_pkg::REQ_KEY) && key_ok))
                begin
                    digit_count_next = '0;
                    match_flags_next = '0;
                end
            end
            default:
            begin
                digit_count_next = '0;
            end
        endcase

        // position wraps in the 3-bit display field; no symbol without a position
        if (res.shown_position == '0)
            res.shown_symbol = '0;

        res.mode_now = mode_next;
        res.bolt_now = bolt_next;

        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            code_next[i] = (code_we && (idx == IDX_W'(i))) ? item.key_value : code_reg[i];
        end
    end

    // ---- state ---------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= kcl_pkg::MODE_IDLE;
            digit_count_reg <= '0;
            match_flags_reg <= '0;
            last_ok_reg     <= 1'b0;
            tries_reg       <= kcl_pkg::TRIES_RESET;
            backoff_reg     <= kcl_pkg::BACKOFF_RESET;
            bolt_reg        <= 1'b1;
            for (int i = 0; i < CODE_LENGTH; i++)
            begin
                code_reg[i] <= kcl_pkg::reset_digit(i);
            end
        end
        else if (step)
        begin
            mode_reg        <= mode_next;
            digit_count_reg <= digit_count_next;
            match_flags_reg <= match_flags_next;
            last_ok_reg     <= last_ok_next;
            tries_reg       <= tries_next;
            backoff_reg     <= backoff_next;
            bolt_reg        <= bolt_next;
            for (int i = 0; i < CODE_LENGTH; i++)
            begin
                code_reg[i] <= code_next[i];
            end
        end
    end

    // ---- assertions ----------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= CNT_W'(CODE_LENGTH))
        else $error("digit count beyond code length");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == kcl_pkg::MODE_IDLE) |-> (digit_count_reg == '0) && (match_flags_reg == '0))
        else $error("entry not cleared while awaiting activation");

    a_backoff_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(backoff_reg))
        else $error("backoff is not a power of two");

    a_verdict_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (res.verdict != kcl_pkg::VERDICT_NONE)) |=> (mode_reg == kcl_pkg::MODE_VERDICT))
        else $error("verdict given without entering verdict mode");

endmodule

`default_nettype wire

// ----- rtl/core/keypad_code_lock_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Keypad code lock. Requests (key press, re-enter, reset/change, sensor sample) arrive on
// the request channel, and every accepted item gives exactly one result item. An item passes
// an input register and then the lock logic, which updates the lock state and loads the
// result register together, and a result is offered from the edge that loads it. The lock logic
// waits while an untaken result is held, and a new item is taken every cycle as long as the
// result register is emptied. The three registers (activation threshold, free tries, backoff
// cap) are written through the cfg port; the user must write them only while no item is in
// flight, which the block does not enforce. Writes to unused indexes are dropped.
module keypad_code_lock_controller #(
    parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    kcl_req_if.sink                             request,
    kcl_res_if.source                           result,
    input  wire                                 cfg_wr_en,
    input  wire [kcl_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire [kcl_pkg::CFG_DATA_W-1:0]       cfg_data
);

    kcl_pkg::cfg_t         cfg_reg, cfg_next;
    kcl_pkg::req_item_t    req_reg;
    kcl_pkg::res_item_t    res_reg;
    kcl_pkg::res_item_t    step_res;
    logic                  in_full_reg, in_full_next;
    logic                  out_full_reg, out_full_next;
    logic                  advance;
    logic                  take;

    // ---- configuration -------------------------------------------------
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                kcl_pkg::CFG_THRESHOLD:
                    cfg_next.threshold   = cfg_data[kcl_pkg::SAMPLE_W-1:0];
                kcl_pkg::CFG_FREE_TRIES:
                    cfg_next.free_tries  = cfg_data[kcl_pkg::TRIES_W-1:0];
                kcl_pkg::CFG_BACKOFF_CAP:
                    cfg_next.backoff_cap = cfg_data[kcl_pkg::CAP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold   <= kcl_pkg::THRESHOLD_RESET;
            cfg_reg.free_tries  <= kcl_pkg::FREE_TRIES_RESET;
            cfg_reg.backoff_cap <= kcl_pkg::BACKOFF_CAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---- handshake -----------------------------------------------------
    // the lock logic steps when an item waits and the result register is free or draining
    always_comb
    begin
        advance       = in_full_reg && (!out_full_reg || result.ready);
        request.ready = !in_full_reg || advance;
        take          = request.valid && request.ready;

        in_full_next = in_full_reg;
        if (take)
            in_full_next = 1'b1;
        else if (advance)
            in_full_next = 1'b0;

        out_full_next = out_full_reg;
        if (advance)
            out_full_next = 1'b1;
        else if (result.ready)
            out_full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg.req_type      <= request.req_type;
            req_reg.key_value     <= request.key_value;
            req_reg.sensor_sample <= request.sensor_sample;
        end
        if (advance)
            res_reg <= step_res;
    end

    kcl_engine #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (req_reg),
        .cfg   (cfg_reg),
        .res   (step_res)
    );

    always_comb
    begin
        result.valid          = out_full_reg;
        result.mode_now       = res_reg.mode_now;
        result.shown_position = res_reg.shown_position;
        result.shown_symbol   = res_reg.shown_symbol;
        result.verdict        = res_reg.verdict;
        result.alarm_flashes  = res_reg.alarm_flashes;
        result.motor_cmd      = res_reg.motor_cmd;
        result.bolt_now       = res_reg.bolt_now;
        result.code_done      = res_reg.code_done;
        result.just_activated = res_reg.just_activated;
    end

endmodule

`default_nettype wire
